### design/fmpr_pkg.sv
// Shared types and constants for the ordered queue with lowest-priority extraction.
package fmpr_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int HANDLE_W      = 32;
    localparam int PRIO_W        = 32;
    localparam int ENTRY_W       = HANDLE_W + PRIO_W;

    localparam logic signed [PRIO_W-1:0] INT_MAX = 32'sh7FFF_FFFF;

    typedef enum logic [1:0] {
        MODE_APPEND  = 2'd0,
        MODE_POP     = 2'd1,
        MODE_EXTRACT = 2'd2,
        MODE_IGNORE  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_NONE  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } state_t;

endpackage

### design/fmpr_req_if.sv
// Request channel: valid/ready handshake carrying one queue request.
interface fmpr_req_if;

    logic                                valid;
    logic                                ready;
    fmpr_pkg::mode_t                     mode;
    logic [fmpr_pkg::HANDLE_W-1:0]       element_handle;
    logic signed [fmpr_pkg::PRIO_W-1:0]  entry_priority;

    modport source (output valid, output mode, output element_handle,
                    output entry_priority, input ready);
    modport sink   (input valid, input mode, input element_handle,
                    input entry_priority, output ready);

endinterface

### design/fmpr_rsp_if.sv
// Response channel: valid/ready handshake carrying one queue result.
interface fmpr_rsp_if #(
    parameter int CNT_W = $clog2(fmpr_pkg::DEPTH_DEFAULT + 1)
);

    logic                                valid;
    logic                                ready;
    logic [fmpr_pkg::HANDLE_W-1:0]       out_handle;
    logic signed [fmpr_pkg::PRIO_W-1:0]  out_priority;
    fmpr_pkg::status_t                   status;
    logic [CNT_W-1:0]                    entry_count;

    modport source (output valid, output out_handle, output out_priority,
                    output status, output entry_count, input ready);
    modport sink   (input valid, input out_handle, input out_priority,
                    input status, input entry_count, output ready);

endinterface

### design/fmpr_mem.sv
// Entry store: one write port, one read port, registered read data.
module fmpr_mem #(
    parameter int DEPTH = fmpr_pkg::DEPTH_DEFAULT,
    parameter int WIDTH = fmpr_pkg::ENTRY_W
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### design/fifo_with_min_priority_removal.sv
// Top level: ordered queue with FIFO pop and stable lowest-priority extraction.
//
// Channels: req (sink) takes one transaction per request: mode, element_handle,
// entry_priority. rsp (source) returns exactly one transaction per request:
// out_handle, out_priority, status and entry_count after the request.
// Entries live in a circular buffer in one synchronous RAM (head pointer plus
// count); logical position i sits at (head + i) mod DEPTH.
// Sequence, accept to rsp.valid, with n entries held:
//   append, ignored mode, any error except no-eligible-entry: straight to S_DONE
//   pop: S_POP takes the head entry, then S_DONE
//   extract: S_SCAN picks the entry (one RAM read per cycle over all
//   entries), then, unless it is the tail, S_SHIFT closes the gap behind position p, one
//   entry moved per cycle through the RAM read/write ports; then S_DONE.
// Only one request is worked on at a time; a new request is accepted only after
// the current one leaves S_DONE, so an extract holds it off through scan and sweep.
// Reset empties the queue at once (count and head cleared); RAM contents stay
// undefined and are never read below the count. When the receiver stalls the
// finished result waits in the output register; the next request is still
// accepted and processed, and its result holds in the sequencer until the
// output register frees up.
module fifo_with_min_priority_removal #(
    parameter int DEPTH = fmpr_pkg::DEPTH_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    fmpr_req_if.sink         req,
    fmpr_rsp_if.source       rsp
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int HW    = fmpr_pkg::HANDLE_W;
    localparam int PW    = fmpr_pkg::PRIO_W;
    localparam int EW    = fmpr_pkg::ENTRY_W;

    // Control state
    fmpr_pkg::state_t  state_reg, state_next;
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              pend_reg, pend_next;
    logic              found_reg, found_next;
    logic              out_valid_reg, out_valid_next;

    // Payload and sweep counters
    logic [CNT_W-1:0]         idx_reg, idx_next;
    logic [CNT_W-1:0]         wr_idx_reg, wr_idx_next;
    logic [CNT_W-1:0]         best_pos_reg, best_pos_next;
    logic [HW-1:0]            res_handle_reg, res_handle_next;
    logic signed [PW-1:0]     res_prio_reg, res_prio_next;
    fmpr_pkg::status_t        res_status_reg, res_status_next;
    logic [HW-1:0]            out_handle_reg, out_handle_next;
    logic signed [PW-1:0]     out_prio_reg, out_prio_next;
    fmpr_pkg::status_t        out_status_reg, out_status_next;
    logic [CNT_W-1:0]         out_count_reg, out_count_next;

    // RAM ports
    logic              mem_we;
    logic [PTR_W-1:0]  mem_waddr;
    logic [EW-1:0]     mem_wdata;
    logic [PTR_W-1:0]  mem_raddr;
    logic [EW-1:0]     mem_rdata;

    logic [HW-1:0]         rd_handle;
    logic signed [PW-1:0]  rd_prio;
    logic signed [PW-1:0]  cmp_prio;
    logic                  do_rd;
    logic                  out_free;

    // Map a logical position onto a RAM address relative to the head.
    function automatic logic [PTR_W-1:0] phys(input logic [PTR_W-1:0] head,
                                              input logic [CNT_W-1:0] idx);
        logic [CNT_W:0] sum;
        sum = {{(CNT_W + 1 - PTR_W){1'b0}}, head} + {1'b0, idx};
        if (sum >= (CNT_W + 1)'(DEPTH))
        begin
            sum = sum - (CNT_W + 1)'(DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

    fmpr_mem #(
        .DEPTH (DEPTH),
        .WIDTH (EW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign rd_handle = mem_rdata[EW-1:PW];
    assign rd_prio   = signed'(mem_rdata[PW-1:0]);
    // Best so far; nothing found yet compares against the excluded maximum.
    assign cmp_prio  = found_reg ? res_prio_reg : fmpr_pkg::INT_MAX;
    assign do_rd     = (idx_reg < count_reg);
    assign out_free  = !out_valid_reg || rsp.ready;

    assign req.ready       = (state_reg == fmpr_pkg::S_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.out_handle  = out_handle_reg;
    assign rsp.out_priority = out_prio_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.entry_count = out_count_reg;

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        pend_next       = pend_reg;
        found_next      = found_reg;
        idx_next        = idx_reg;
        wr_idx_next     = wr_idx_reg;
        best_pos_next   = best_pos_reg;
        res_handle_next = res_handle_reg;
        res_prio_next   = res_prio_reg;
        res_status_next = res_status_reg;
        out_handle_next = out_handle_reg;
        out_prio_next   = out_prio_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;

        mem_we    = 1'b0;
        mem_waddr = phys(head_reg, count_reg);
        mem_wdata = {req.element_handle, req.entry_priority};
        mem_raddr = head_reg;

        unique case (state_reg)
            fmpr_pkg::S_IDLE:
            begin
                if (req.valid)
                begin
                    res_handle_next = '0;
                    res_prio_next   = '0;
                    res_status_next = fmpr_pkg::ST_OK;
                    state_next      = fmpr_pkg::S_DONE;
                    unique case (req.mode)
                        fmpr_pkg::MODE_APPEND:
                        begin
                            if (count_reg == CNT_W'(DEPTH))
                            begin
                                res_status_next = fmpr_pkg::ST_FULL;
                            end
                            else
                            begin
                                // Write at the tail.
                                mem_we     = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        fmpr_pkg::MODE_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = fmpr_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                state_next = fmpr_pkg::S_POP;
                            end
                        end
                        fmpr_pkg::MODE_EXTRACT:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = fmpr_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                idx_next   = '0;
                                pend_next  = 1'b0;
                                found_next = 1'b0;
                                state_next = fmpr_pkg::S_SCAN;
                            end
                        end
                        fmpr_pkg::MODE_IGNORE:
                        begin
                            res_status_next = fmpr_pkg::ST_OK;
                        end
                        default:
                        begin
                            res_status_next = fmpr_pkg::ST_OK;
                        end
                    endcase
                end
            end

            fmpr_pkg::S_POP:
            begin
                // Head entry read last cycle; advance the head.
                res_handle_next = rd_handle;
                res_prio_next   = rd_prio;
                head_next       = (head_reg == PTR_W'(DEPTH - 1)) ? '0
                                                                   : head_reg + PTR_W'(1);
                count_next      = count_reg - CNT_W'(1);
                state_next      = fmpr_pkg::S_DONE;
            end

            fmpr_pkg::S_SCAN:
            begin
                mem_raddr = phys(head_reg, idx_reg);
                pend_next = do_rd;
                if (do_rd)
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
                if (pend_reg)
                begin
                    // Strict less-than keeps the earliest of equal priorities.
                    if (rd_handle != '0 && rd_prio < cmp_prio)
                    begin
                        found_next      = 1'b1;
                        res_handle_next = rd_handle;
                        res_prio_next   = rd_prio;
                        best_pos_next   = idx_reg - CNT_W'(1);
                    end
                end
                else if (!do_rd)
                begin
                    if (!found_reg)
                    begin
                        res_status_next = fmpr_pkg::ST_NONE;
                        state_next      = fmpr_pkg::S_DONE;
                    end
                    else if (best_pos_reg == count_reg - CNT_W'(1))
                    begin
                        // Chosen entry is the tail: just drop it.
                        count_next = count_reg - CNT_W'(1);
                        state_next = fmpr_pkg::S_DONE;
                    end
                    else
                    begin
                        idx_next    = best_pos_reg + CNT_W'(1);
                        wr_idx_next = best_pos_reg;
                        pend_next   = 1'b0;
                        state_next  = fmpr_pkg::S_SHIFT;
                    end
                end
            end

            fmpr_pkg::S_SHIFT:
            begin
                // Read position i while writing the entry read last cycle one slot down.
                mem_raddr = phys(head_reg, idx_reg);
                pend_next = do_rd;
                if (do_rd)
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
                if (pend_reg)
                begin
                    mem_we      = 1'b1;
                    mem_waddr   = phys(head_reg, wr_idx_reg);
                    mem_wdata   = mem_rdata;
                    wr_idx_next = wr_idx_reg + CNT_W'(1);
                end
                else if (!do_rd)
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = fmpr_pkg::S_DONE;
                end
            end

            fmpr_pkg::S_DONE:
            begin
                // Hold until the output register is free.
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_handle_next = res_handle_reg;
                    out_prio_next   = res_prio_reg;
                    out_status_next = res_status_reg;
                    out_count_next  = count_reg;
                    state_next      = fmpr_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = fmpr_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fmpr_pkg::S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        wr_idx_reg     <= wr_idx_next;
        best_pos_reg   <= best_pos_next;
        res_handle_reg <= res_handle_next;
        res_prio_reg   <= res_prio_next;
        res_status_reg <= res_status_next;
        out_handle_reg <= out_handle_next;
        out_prio_reg   <= out_prio_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
    end

endmodule
